/* hw/rtl/ulebc_pkg.sv */
// ulebc_pkg: shared types and constants of the unsigned LEB128 codec
// no dependencies; imported by the front, queue, back and top modules
`default_nettype none

package ulebc_pkg;

  localparam int VALUE_W = 32;
  localparam int BYTE_W  = 8;
  localparam int GROUP_W = 7;
  localparam int COUNT_W = 3;

  // input function codes
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  // result kind codes
  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  localparam logic [COUNT_W-1:0] MAX_BYTES = 3'd5;
  localparam logic [VALUE_W-1:0] BAD_VALUE = 32'hffff_ffff;

  // classified work item that travels from front to back
  typedef struct packed {
    logic               func;
    logic [VALUE_W-1:0] data;   // value to encode, or byte to decode in the low bits
    logic [COUNT_W-1:0] count;  // encoded length, encode only
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

`default_nettype wire

/* hw/rtl/ulebc_if.sv */
// ulebc_in_if and ulebc_out_if: valid/ready channels of the LEB128 codec
// no dependencies
`default_nettype none

interface ulebc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] value_in;
  logic [7:0]  byte_in;

  modport source (output valid, output func, output value_in, output byte_in, input ready);
  modport sink   (input valid, input func, input value_in, input byte_in, output ready);
endinterface

interface ulebc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  enc_byte;
  logic        last;
  logic [31:0] dec_value;
  logic        dec_error;
  logic [2:0]  byte_count;

  modport source (output valid, output kind, output enc_byte, output last,
                  output dec_value, output dec_error, output byte_count, input ready);
  modport sink   (input valid, input kind, input enc_byte, input last,
                  input dec_value, input dec_error, input byte_count, output ready);
endinterface

`default_nettype wire

/* hw/rtl/uleb128_codec_32bit_core.sv */
// uleb128_codec_32bit_core: top level of the unsigned LEB128 codec
// path: a result passes through the queue entry and then the back end's output register
// throughput: an encode emits one byte per cycle (1 to 5 bytes) while the output is not stalled;
// decode bytes are taken one per cycle likewise; the back end's single output register sets the pace
// reset: synchronous active-high rst empties the queue, ends any encode run and
// clears the decode accumulator and byte count
`default_nettype none

module uleb128_codec_32bit_core
  import ulebc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ulebc_in_if.sink    in_ch,
  ulebc_out_if.source out_ch
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  // accept and classify
  ulebc_front u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decoupling queue
  ulebc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // execute and emit results
  ulebc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

/* hw/rtl/ulebc_front.sv */
// ulebc_front: accepts input transfers and classifies them into commands
// depends on ulebc_pkg and ulebc_in_if
`default_nettype none

module ulebc_front
  import ulebc_pkg::*;
(
  ulebc_in_if.sink   in_ch,
  input  wire logic  q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [COUNT_W-1:0] enc_count;

  // encoded length from the highest nonzero 7-bit group
  always_comb begin
    if (in_ch.value_in[31:28] != '0) begin
      enc_count = 3'd5;
    end else if (in_ch.value_in[27:21] != '0) begin
      enc_count = 3'd4;
    end else if (in_ch.value_in[20:14] != '0) begin
      enc_count = 3'd3;
    end else if (in_ch.value_in[13:7] != '0) begin
      enc_count = 3'd2;
    end else begin
      enc_count = 3'd1;
    end
  end

  // accept whenever the queue has room
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_cmd.func = in_ch.func;
    if (in_ch.func == FUNC_ENCODE) begin
      push_cmd.data  = in_ch.value_in;
      push_cmd.count = enc_count;
    end else begin
      push_cmd.data  = {{(VALUE_W-BYTE_W){1'b0}}, in_ch.byte_in};
      push_cmd.count = 3'd1;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ulebc_queue.sv */
// ulebc_queue: small command queue between front and back
// depends on ulebc_pkg
`default_nettype none

module ulebc_queue
  import ulebc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ulebc_back.sv */
// ulebc_back: runs commands, emits encoded bytes and decoded values
// depends on ulebc_pkg and ulebc_out_if
`default_nettype none

module ulebc_back
  import ulebc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   head_valid,
  input  cmd_t        head_cmd,
  output logic        pop,
  ulebc_out_if.source out_ch
);

  // encode run state
  logic               busy;
  logic [VALUE_W-1:0] cur;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] total;

  // decode state
  logic [VALUE_W-1:0] accum;
  logic [COUNT_W-1:0] seen;

  // output register
  logic               out_valid;
  logic               out_kind;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_last;
  logic [VALUE_W-1:0] out_value;
  logic               out_error;
  logic [COUNT_W-1:0] out_count;

  logic               can_load;
  logic [VALUE_W-1:0] src_val;
  logic [COUNT_W-1:0] src_idx;
  logic [COUNT_W-1:0] src_total;
  logic [COUNT_W-1:0] idx_inc;
  logic               enc_last;
  logic               start_enc;
  logic               start_dec;
  logic [VALUE_W-1:0] group_shifted;
  logic [VALUE_W-1:0] accum_next;
  logic [COUNT_W-1:0] seen_inc;
  logic               dec_cont;
  logic               dec_done;

  assign can_load  = !out_valid || out_ch.ready;
  assign pop       = head_valid && !busy && can_load;
  assign start_enc = pop && (head_cmd.func == FUNC_ENCODE);
  assign start_dec = pop && (head_cmd.func == FUNC_DECODE);

  // byte source: a running encode, or the head command
  assign src_val   = busy ? cur   : head_cmd.data;
  assign src_idx   = busy ? idx   : '0;
  assign src_total = busy ? total : head_cmd.count;
  assign idx_inc   = src_idx + 3'd1;
  assign enc_last  = (idx_inc == src_total);

  // place the 7-bit group at its running shift
  always_comb begin
    case (seen)
      3'd0:    group_shifted = {25'b0, head_cmd.data[6:0]};
      3'd1:    group_shifted = {18'b0, head_cmd.data[6:0], 7'b0};
      3'd2:    group_shifted = {11'b0, head_cmd.data[6:0], 14'b0};
      3'd3:    group_shifted = {4'b0, head_cmd.data[6:0], 21'b0};
      3'd4:    group_shifted = {head_cmd.data[3:0], 28'b0};
      default: group_shifted = '0;
    endcase
  end

  assign accum_next = accum | group_shifted;
  assign seen_inc   = seen + 3'd1;
  assign dec_cont   = head_cmd.data[7];
  assign dec_done   = !dec_cont || (seen_inc == MAX_BYTES);

  // encode run and decode accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      idx   <= '0;
      total <= '0;
      accum <= '0;
      seen  <= '0;
    end else begin
      if ((busy && can_load) || start_enc) begin
        busy  <= !enc_last;
        idx   <= idx_inc;
        total <= src_total;
      end
      if (start_dec) begin
        accum <= dec_done ? '0 : accum_next;
        seen  <= dec_done ? '0 : seen_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((busy && can_load) || start_enc) begin
      cur <= src_val >> GROUP_W;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= busy || start_enc || (start_dec && dec_done);
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (can_load) begin
      if (busy || start_enc) begin
        out_kind  <= KIND_ENC;
        out_byte  <= {!enc_last, src_val[6:0]};
        out_last  <= enc_last;
        out_value <= '0;
        out_error <= 1'b0;
        out_count <= enc_last ? src_total : '0;
      end else begin
        out_kind  <= KIND_DEC;
        out_byte  <= '0;
        out_last  <= 1'b1;
        out_value <= dec_cont ? BAD_VALUE : accum_next;
        out_error <= dec_cont;
        out_count <= seen_inc;
      end
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.kind       = out_kind;
  assign out_ch.enc_byte   = out_byte;
  assign out_ch.last       = out_last;
  assign out_ch.dec_value  = out_value;
  assign out_ch.dec_error  = out_error;
  assign out_ch.byte_count = out_count;

`ifndef SYNTHESIS
  // a running encode always has a byte waiting in the output register
  a_busy_has_output: assert property (@(posedge clk) disable iff (rst)
    busy |-> out_valid)
    else $error("encode run without a pending output byte");

  // a non-final encoded byte means the run is still going
  a_more_bytes_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_ENC && !out_last) |-> busy)
    else $error("continuation byte without a running encode");

  // malformed results always report five bytes
  a_error_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_error) |-> (out_count == MAX_BYTES && out_kind == KIND_DEC))
    else $error("decode error with wrong byte count");

  // decode progress stays below five between items
  a_seen_range: assert property (@(posedge clk) disable iff (rst)
    seen < MAX_BYTES)
    else $error("decode byte count out of range");
`endif

endmodule

`default_nettype wire

/* dv/uleb_checker.sv */
// uleb_checker: watches both codec channels, predicts every result and compares it
// depends on ulebc_pkg and the ulebc_in_if / ulebc_out_if interfaces
module uleb_checker
  import ulebc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  ulebc_in_if   in_ch,
  ulebc_out_if  out_ch,
  output int    fail_count,
  output int    pending
);

  // one result as seen on the output channel
  typedef struct packed {
    logic               kind;
    logic [BYTE_W-1:0]  enc_byte;
    logic               last;
    logic [VALUE_W-1:0] dec_value;
    logic               dec_error;
    logic [COUNT_W-1:0] byte_count;
  } codec_out_t;

  codec_out_t         codec_out_q[$];
  logic [VALUE_W-1:0] acc;
  logic [COUNT_W-1:0] seen;

  initial fail_count = 0;

  task automatic flag_error(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // work out the results of one accepted item and queue them
  task automatic run_codec(input logic f, input logic [VALUE_W-1:0] v,
                           input logic [BYTE_W-1:0] b);
    codec_out_t         r;
    logic [VALUE_W-1:0] rest;
    logic [COUNT_W-1:0] n;
    if (f == FUNC_ENCODE) begin
      rest = v;
      n = '0;
      // lowest group first, continuation bit on all but the final byte
      do begin
        r = '0;
        r.kind = KIND_ENC;
        r.enc_byte = {1'b0, rest[GROUP_W-1:0]};
        rest = rest >> GROUP_W;
        n++;
        if (rest != 0) begin
          r.enc_byte[BYTE_W-1] = 1'b1;
        end else begin
          r.last = 1'b1;
          r.byte_count = n;
        end
        codec_out_q = {codec_out_q, r};
      end while (rest != 0);
    end else begin
      // bits shifted past bit 31 fall off
      acc = acc | ({25'd0, b[GROUP_W-1:0]} << (GROUP_W * seen));
      seen++;
      if (b[BYTE_W-1] && seen < MAX_BYTES) return;
      r = '0;
      r.kind = KIND_DEC;
      r.last = 1'b1;
      r.dec_error = b[BYTE_W-1];
      r.dec_value = b[BYTE_W-1] ? BAD_VALUE : acc;
      r.byte_count = seen;
      codec_out_q = {codec_out_q, r};
      acc = '0;
      seen = '0;
    end
  endtask

  // predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    codec_out_t got, want;
    if (rst) begin
      acc = '0;
      seen = '0;
      codec_out_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        run_codec(in_ch.func, in_ch.value_in, in_ch.byte_in);
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.kind, out_ch.enc_byte, out_ch.last, out_ch.dec_value,
               out_ch.dec_error, out_ch.byte_count};
        if (codec_out_q.size() == 0) begin
          flag_error($sformatf("unexpected result 0x%0h", got));
        end else begin
          want = codec_out_q[0];
          codec_out_q.delete(0);
          check_field("kind", 32'(got.kind), 32'(want.kind));
          check_field("enc_byte", 32'(got.enc_byte), 32'(want.enc_byte));
          check_field("last", 32'(got.last), 32'(want.last));
          check_field("dec_value", got.dec_value, want.dec_value);
          check_field("dec_error", 32'(got.dec_error), 32'(want.dec_error));
          check_field("byte_count", 32'(got.byte_count), 32'(want.byte_count));
        end
      end
    end
    pending <= codec_out_q.size();
  end

endmodule

/* dv/tb.sv */
// tb: drives the LEB128 codec with directed and random encode/decode traffic
// depends on ulebc_pkg, the channel interfaces, uleb_checker and the codec core
module tb;
  import ulebc_pkg::*;

  localparam int ITEM_TOTAL  = 380;
  localparam int CALM_AFTER  = 320;
  localparam int QUIET_LIMIT = 2000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   sent;
  int   gap_pct;
  int   stall_pct;
  int   quiet_cycles;

  ulebc_in_if  in_ch();
  ulebc_out_if out_ch();

  uleb128_codec_32bit_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  uleb_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // give up when nothing transfers for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** uleb128_codec_32bit_core: FAILED **");
      $finish;
    end
  end

  // receiver back-pressure in bursts
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // one input transfer, with an optional gap in front; returns at a falling edge
  task automatic send_item(input logic f, input logic [VALUE_W-1:0] v,
                           input logic [BYTE_W-1:0] b);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.value_in <= v;
    in_ch.byte_in  <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic enc(input logic [VALUE_W-1:0] v);
    send_item(FUNC_ENCODE, v, BYTE_W'($urandom));
  endtask

  task automatic dec(input logic [BYTE_W-1:0] b);
    send_item(FUNC_DECODE, $urandom, b);
  endtask

  // hold the sender until every predicted result has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // spread of lengths from one to five bytes
  function automatic logic [VALUE_W-1:0] rand_value();
    if ($urandom_range(0, 15) == 0) return '0;
    return $urandom >> $urandom_range(0, 31);
  endfunction

  // well-formed value of 1 to 5 bytes, sometimes malformed or interleaved with encodes
  task automatic send_decode_seq();
    int         len;
    logic [7:0] b;
    len = $urandom_range(1, 5);
    for (int i = 0; i < len; i++) begin
      b = BYTE_W'($urandom);
      b[7] = (i < len - 1);
      if (i == len - 1 && len == 5 && $urandom_range(0, 3) == 0) b[7] = 1'b1;
      dec(b);
      if (i < len - 1 && $urandom_range(0, 9) == 0) enc(rand_value());
    end
  endtask

  initial begin
    int pick;
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_ENCODE;
    in_ch.value_in = '0;
    in_ch.byte_in  = '0;
    sent           = 0;
    gap_pct        = 20;
    stall_pct      = 20;
    quiet_cycles   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // encode at every length boundary
    enc(32'h0000_0000);
    enc(32'h0000_0001);
    enc(32'h0000_007f);
    enc(32'h0000_0080);
    enc(32'h0000_3fff);
    enc(32'h0000_4000);
    enc(32'h001f_ffff);
    enc(32'h0020_0000);
    enc(32'h0fff_ffff);
    enc(32'h1000_0000);
    enc(32'hffff_ffff);
    // single zero byte
    dec(8'h00);
    // overlong fifth byte, high bits dropped
    dec(8'hff);
    dec(8'hff);
    dec(8'hff);
    dec(8'hff);
    dec(8'h7f);
    // fifth byte still continues
    dec(8'h80);
    dec(8'h80);
    dec(8'h80);
    dec(8'h80);
    dec(8'h80);
    // encode in the middle of a decode
    dec(8'h85);
    enc(32'd300);
    dec(8'h01);
    drain();

    // random traffic, mostly well-formed values
    while (sent < ITEM_TOTAL) begin
      if (sent >= CALM_AFTER) begin
        gap_pct = 0;
        stall_pct = 0;
      end else if ($urandom_range(0, 39) == 0) begin
        gap_pct = $urandom_range(0, 2) * 20;
        stall_pct = $urandom_range(0, 2) * 20;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) enc(rand_value());
      else if (pick < 85) send_decode_seq();
      else dec(BYTE_W'($urandom));
      if (sent < CALM_AFTER && $urandom_range(0, 49) == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** uleb128_codec_32bit_core: PASSED **");
    end else begin
      $display("** uleb128_codec_32bit_core: FAILED **");
    end
    $finish;
  end

endmodule
